/* sv/rmmst_pkg.sv */
`timescale 1ns / 1ps

package rmmst_pkg;

	localparam int DATA_W      = 48;
	localparam int IDX_W       = 10;
	localparam int ENTRIES_DEF = 1024;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// identities of the two trees
	localparam data_t MAX_IDENT = {1'b1, {(DATA_W-1){1'b0}}};
	localparam data_t MIN_IDENT = {1'b0, {(DATA_W-1){1'b1}}};

	// item kinds
	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic leaf_wr;
		logic sib_rd;
		logic par_wr;
		logic lo_step;
		logic hi_step;
		logic out_load;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic oob;
		logic empty;
		logic lo_lt_hi;
		logic root;
		logic out_busy;
	} dp_stat_t;

endpackage

/* sv/rmmst_in_if.sv */
`timescale 1ns / 1ps

interface rmmst_in_if import rmmst_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  kind;
	idx_t  first_index;
	idx_t  last_index;
	data_t value;

	modport source (
		output valid, kind, first_index, last_index, value,
		input  ready
	);

	modport sink (
		input  valid, kind, first_index, last_index, value,
		output ready
	);
endinterface

/* sv/rmmst_out_if.sv */
`timescale 1ns / 1ps

interface rmmst_out_if import rmmst_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t range_max;
	data_t range_min;

	modport source (
		output valid, range_max, range_min,
		input  ready
	);

	modport sink (
		input  valid, range_max, range_min,
		output ready
	);
endinterface

/* sv/rmmst_ctrl.sv */
`timescale 1ns / 1ps

module rmmst_ctrl import rmmst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_kind,
	input  dp_stat_t stat,
	output logic     in_ready,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ULEAF = 3'd2;
	localparam logic [2:0] S_URD   = 3'd3;
	localparam logic [2:0] S_UWR   = 3'd4;
	localparam logic [2:0] S_QLO   = 3'd5;
	localparam logic [2:0] S_QHI   = 3'd6;
	localparam logic [2:0] S_QDONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// sequence the clearing pass, the leaf-to-root walk and the query walk
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_kind == KIND_QUERY) ? S_QLO : S_ULEAF;
				end
			end
			S_ULEAF: begin
				if (stat.oob) begin
					state_d = S_IDLE;
				end else begin
					cmd.leaf_wr = 1'b1;
					state_d     = S_URD;
				end
			end
			S_URD: begin
				if (stat.root) begin
					state_d = S_IDLE;
				end else begin
					cmd.sib_rd = 1'b1;
					state_d    = S_UWR;
				end
			end
			S_UWR: begin
				cmd.par_wr = 1'b1;
				state_d    = S_URD;
			end
			S_QLO: begin
				if (stat.empty || !stat.lo_lt_hi) begin
					state_d = S_QDONE;
				end else begin
					cmd.lo_step = 1'b1;
					state_d     = S_QHI;
				end
			end
			S_QHI: begin
				cmd.hi_step = 1'b1;
				state_d     = S_QLO;
			end
			S_QDONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/rmmst_dp.sv */
`timescale 1ns / 1ps

module rmmst_dp import rmmst_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  idx_t     first_index,
	input  idx_t     last_index,
	input  data_t    value,
	input  logic     out_ready,
	output dp_stat_t stat,
	output logic     out_valid,
	output data_t    range_max,
	output data_t    range_min
);

	localparam int DEPTH = 2 * ENTRIES;
	localparam int NW    = $clog2(DEPTH);
	localparam int AW1   = NW + 1;
	localparam int CW    = (AW1 > IDX_W + 1) ? AW1 : IDX_W + 1;

	localparam logic [CW-1:0] ENT_C   = CW'(ENTRIES);
	localparam logic [CW-1:0] LAST_C  = CW'(ENTRIES - 1);
	localparam logic [NW-1:0] CLR_END = NW'(DEPTH - 1);
	localparam logic [NW-1:0] ROOT    = NW'(1);

	// node word: max tree in the upper half, min tree in the lower half
	logic [2*DATA_W-1:0] mem [DEPTH];
	logic [2*DATA_W-1:0] rdata_q;
	logic [2*DATA_W-1:0] wr_data;
	logic [NW-1:0]       wr_addr;
	logic [NW-1:0]       rd_addr;
	logic                wr_en;
	logic                rd_en;

	logic [CW-1:0]  first_x;
	logic [CW-1:0]  last_x;
	logic [CW-1:0]  hi_idx;
	logic [CW-1:0]  lo_n;
	logic [CW-1:0]  hi_n;
	logic [AW1-1:0] hi_dec;

	logic [NW-1:0]  clr_q;
	logic [NW-1:0]  node_q;
	logic [AW1-1:0] lo_q;
	logic [AW1-1:0] hi_q;
	logic           oob_q;
	logic           empty_q;
	logic           qrd_q;
	data_t          cur_max_q;
	data_t          cur_min_q;
	data_t          acc_max_q;
	data_t          acc_min_q;
	data_t          rd_max;
	data_t          rd_min;
	data_t          p_max;
	data_t          p_min;
	data_t          a_max;
	data_t          a_min;
	logic           out_valid_q;
	data_t          out_max_q;
	data_t          out_min_q;

	// map the incoming indexes onto tree nodes, saturating the upper bound
	always_comb begin
		first_x = {{(CW-IDX_W){1'b0}}, first_index};
		last_x  = {{(CW-IDX_W){1'b0}}, last_index};
		hi_idx  = (last_x > LAST_C) ? LAST_C : last_x;
		lo_n    = first_x + ENT_C;
		hi_n    = hi_idx + ENT_C + CW'(1);
	end

	assign hi_dec = hi_q - AW1'(hi_q[0]);

	assign rd_max = rdata_q[2*DATA_W-1:DATA_W];
	assign rd_min = rdata_q[DATA_W-1:0];

	// combine the walked value with the sibling, and the accumulator with a node
	always_comb begin
		p_max = (cur_max_q > rd_max) ? cur_max_q : rd_max;
		p_min = (cur_min_q < rd_min) ? cur_min_q : rd_min;
		a_max = (acc_max_q > rd_max) ? acc_max_q : rd_max;
		a_min = (acc_min_q < rd_min) ? acc_min_q : rd_min;
	end

	// select the read port address
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		priority if (cmd.sib_rd) begin
			rd_en   = 1'b1;
			rd_addr = node_q ^ ROOT;
		end else if (cmd.lo_step && lo_q[0]) begin
			rd_en   = 1'b1;
			rd_addr = lo_q[NW-1:0];
		end else if (cmd.hi_step && hi_q[0]) begin
			rd_en   = 1'b1;
			rd_addr = hi_dec[NW-1:0];
		end else begin
			rd_en   = 1'b0;
		end
	end

	// select the write port address and data
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {MAX_IDENT, MIN_IDENT};
		priority if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.leaf_wr) begin
			wr_en   = 1'b1;
			wr_addr = node_q;
			wr_data = {cur_max_q, cur_min_q};
		end else if (cmd.par_wr) begin
			wr_en   = 1'b1;
			wr_addr = node_q >> 1;
			wr_data = {p_max, p_min};
		end else begin
			wr_en   = 1'b0;
		end
	end

	// tree node storage
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// advance the clearing pass and track pending query reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			qrd_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + NW'(1);
			qrd_q <= (cmd.lo_step && lo_q[0]) || (cmd.hi_step && hi_q[0]);
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q    <= lo_n[NW-1:0];
			lo_q      <= lo_n[AW1-1:0];
			hi_q      <= hi_n[AW1-1:0];
			oob_q     <= (first_x >= ENT_C);
			empty_q   <= (first_x > hi_idx);
			cur_max_q <= value;
			cur_min_q <= value;
		end else if (cmd.par_wr) begin
			node_q    <= node_q >> 1;
			cur_max_q <= p_max;
			cur_min_q <= p_min;
		end else if (cmd.lo_step) begin
			if (lo_q[0]) lo_q <= lo_q + AW1'(1);
		end else if (cmd.hi_step) begin
			lo_q <= lo_q >> 1;
			hi_q <= hi_dec >> 1;
		end
	end

	// accumulate query results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_max_q <= MAX_IDENT;
			acc_min_q <= MIN_IDENT;
		end else if (qrd_q) begin
			acc_max_q <= a_max;
			acc_min_q <= a_min;
		end
	end

	// output register: hold the item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_max_q <= acc_max_q;
			out_min_q <= acc_min_q;
		end
	end

	assign out_valid = out_valid_q;
	assign range_max = out_max_q;
	assign range_min = out_min_q;

	always_comb begin
		stat.clr_last = (clr_q == CLR_END);
		stat.oob      = oob_q;
		stat.empty    = empty_q;
		stat.lo_lt_hi = (lo_q < hi_q);
		stat.root     = (node_q == ROOT);
		stat.out_busy = out_valid_q && !out_ready;
	end

endmodule

/* sv/range_min_max_segment_tree.sv */
`timescale 1ns / 1ps

// Range max/min segment tree over ENTRIES signed 48-bit elements, stored as
// one 96-bit node word per tree node in a single-port-read, single-port-write
// memory of 2*ENTRIES words. After reset a clearing pass writes the identities
// into every node, one node a cycle, and no item is taken until it ends. One
// item is worked on at a time, one memory access per cycle. An assign item
// goes through the accept cycle, the leaf write, a sibling read and a parent
// write per level, and the check at the root; an assign beyond the array is
// dropped after the accept cycle without a write. A query item walks the
// nodes level by level, a low step and a high step per level, each of which
// may read a node on the one read port; an empty range skips the walk. Its
// result waits in an output register while the next item is accepted, and a
// query that finishes while that register is still held stalls until it is
// taken.
module range_min_max_segment_tree import rmmst_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rmmst_in_if.sink     in_ch,
	rmmst_out_if.source  out_ch
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rmmst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.stat     (stat),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	rmmst_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.first_index (in_ch.first_index),
		.last_index  (in_ch.last_index),
		.value       (in_ch.value),
		.out_ready   (out_ch.ready),
		.stat        (stat),
		.out_valid   (out_ch.valid),
		.range_max   (out_ch.range_max),
		.range_min   (out_ch.range_min)
	);

endmodule

/* tb/tb_range_min_max_segment_tree.sv */
`timescale 1ns / 1ps

module tb_range_min_max_segment_tree import rmmst_pkg::*;;

	localparam int N_ELEM    = ENTRIES_DEF;
	localparam int IDLE_PCT  = 17;
	localparam int N_RANDOM  = 1400;

	typedef struct {
		data_t hi;
		data_t lo;
	} extrema_t;

	// Tracks the element array as the two trees see it and queues the
	// max/min each query should return, oldest first.
	class extrema_scoreboard;
		data_t    elem_max[N_ELEM];
		data_t    elem_min[N_ELEM];
		extrema_t expected_extrema[$];
		int       mismatches;

		function new();
			foreach (elem_max[i]) begin
				elem_max[i] = MAX_IDENT;
				elem_min[i] = MIN_IDENT;
			end
			mismatches = 0;
		endfunction

		// Update the element array, or queue the extrema of the range
		function void note_item(logic kind, idx_t first, idx_t last, data_t value);
			int       lo_i;
			int       hi_i;
			extrema_t r;
			lo_i = int'(first);
			hi_i = int'(last);
			if (kind == KIND_ASSIGN) begin
				if (lo_i < N_ELEM) begin
					elem_max[lo_i] = value;
					elem_min[lo_i] = value;
				end
			end else begin
				if (hi_i >= N_ELEM)
					hi_i = N_ELEM - 1;
				r.hi = MAX_IDENT;
				r.lo = MIN_IDENT;
				for (int i = lo_i; i <= hi_i; i++) begin
					if (elem_max[i] > r.hi)
						r.hi = elem_max[i];
					if (elem_min[i] < r.lo)
						r.lo = elem_min[i];
				end
				expected_extrema.push_back(r);
			end
		endfunction

		// Compare one result with the oldest pending expectation
		function void match_result(data_t got_max, data_t got_min);
			extrema_t r;
			if (expected_extrema.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result max %0d min %0d", $time,
					got_max, got_min);
				return;
			end
			r = expected_extrema.pop_front();
			if (got_max !== r.hi) begin
				mismatches++;
				$display("%0t: range_max expected %0d, got %0d", $time, r.hi,
					got_max);
			end
			if (got_min !== r.lo) begin
				mismatches++;
				$display("%0t: range_min expected %0d, got %0d", $time, r.lo,
					got_min);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;

	rmmst_in_if  in_ch();
	rmmst_out_if out_ch();

	extrema_scoreboard sb = new();

	range_min_max_segment_tree #(.ENTRIES(N_ELEM)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb_range_min_max_segment_tree: FAIL");
		$finish;
	end

	// Check accepted results, then decide whether to stall the next cycle
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.match_result(out_ch.range_max, out_ch.range_min);
		out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Present one item, with random idle cycles ahead of it, and hold it
	// until accepted
	task automatic send_item(input logic kind, input int first, input int last,
		input data_t value);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid       <= 1'b1;
		in_ch.kind        <= kind;
		in_ch.first_index <= idx_t'(first);
		in_ch.last_index  <= idx_t'(last);
		in_ch.value       <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_item(kind, idx_t'(first), idx_t'(last), value);
	endtask

	function automatic data_t rand_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				return MAX_IDENT;
			end
			1: begin
				return MIN_IDENT;
			end
			2: begin
				return data_t'($signed($urandom_range(0, 20)) - 10);
			end
			default: begin
				return data_t'({$urandom(), $urandom()});
			end
		endcase
	endfunction

	initial begin
		int    kind_sel;
		int    lo;
		int    hi;
		int    tmp;
		data_t v;

		arst_n            = 1'b0;
		steady            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.kind        = KIND_ASSIGN;
		in_ch.first_index = '0;
		in_ch.last_index  = '0;
		in_ch.value       = '0;
		out_ch.ready      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty tree, empty ranges, extreme values and indexes
		send_item(KIND_QUERY, 0, N_ELEM - 1, '0);
		send_item(KIND_QUERY, 5, 3, '0);
		send_item(KIND_ASSIGN, 0, 0, MAX_IDENT);
		send_item(KIND_ASSIGN, N_ELEM - 1, 0, MIN_IDENT);
		send_item(KIND_QUERY, 0, N_ELEM - 1, '0);
		send_item(KIND_QUERY, 0, 0, '0);
		send_item(KIND_QUERY, N_ELEM - 1, N_ELEM - 1, '0);
		// never-written elements only
		send_item(KIND_QUERY, 1, N_ELEM - 2, '0);
		send_item(KIND_ASSIGN, 512, 0, '0);
		send_item(KIND_ASSIGN, 511, 0, data_t'(-1));
		send_item(KIND_QUERY, 500, 520, '0);
		send_item(KIND_QUERY, N_ELEM - 1, 0, '0);
		// overwrite an element
		send_item(KIND_ASSIGN, 0, 0, data_t'(1));
		send_item(KIND_QUERY, 0, 1, '0);
		send_item(KIND_QUERY, 0, N_ELEM - 1, '0);
		// fields that the kind ignores carry noise
		send_item(KIND_ASSIGN, 7, 1023, data_t'(48'h5555_5555_5555));
		send_item(KIND_QUERY, 2, 9, data_t'(48'h2aaa_aaaa_aaaa));
		send_item(KIND_QUERY, 10, 10, '0);
		send_item(KIND_ASSIGN, 1, 0, data_t'(48'h7fff_ffff_fffe));
		send_item(KIND_QUERY, 1, 1, '0);
		send_item(KIND_QUERY, 0, 1023, data_t'(48'hffff_ffff_ffff));

		// Random mix; a stretch in the middle runs without idling
		for (int n = 0; n < N_RANDOM; n++) begin
			steady = (n >= 500 && n < 800);
			if ($urandom_range(0, 1) == 0) begin
				kind_sel = $urandom_range(0, 9);
				if (kind_sel < 6)
					lo = $urandom_range(0, N_ELEM - 1);
				else if (kind_sel < 8)
					lo = $urandom_range(100, 131);
				else
					lo = (kind_sel == 8) ? 0 : N_ELEM - 1;
				send_item(KIND_ASSIGN, lo, $urandom_range(0, N_ELEM - 1), rand_value());
			end else begin
				kind_sel = $urandom_range(0, 9);
				lo = $urandom_range(0, N_ELEM - 1);
				hi = $urandom_range(0, N_ELEM - 1);
				v  = data_t'({$urandom(), $urandom()});
				case (kind_sel)
					6: begin
						hi = lo + $urandom_range(0, 8);
						if (hi > N_ELEM - 1)
							hi = N_ELEM - 1;
					end
					7: begin
						// first at or above last: an empty range unless the two are equal
						if (lo < hi) begin
							tmp = lo;
							lo  = hi;
							hi  = tmp;
						end
					end
					8: begin
						lo = 0;
						hi = N_ELEM - 1;
					end
					9: begin
					end
					default: begin
						if (lo > hi) begin
							tmp = lo;
							lo  = hi;
							hi  = tmp;
						end
					end
				endcase
				send_item(KIND_QUERY, lo, hi, v);
			end
		end
		steady = 1'b0;
		in_ch.valid <= 1'b0;

		// Drain outstanding queries, then let the block settle
		while (sb.expected_extrema.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_extrema.size() == 0) begin
			$display("tb_range_min_max_segment_tree: PASS");
		end else begin
			$display("tb_range_min_max_segment_tree: FAIL");
		end
		$finish;
	end

endmodule

/* range_min_max_segment_tree.f */
sv/rmmst_pkg.sv
sv/rmmst_in_if.sv
sv/rmmst_out_if.sv
sv/rmmst_ctrl.sv
sv/rmmst_dp.sv
sv/range_min_max_segment_tree.sv
tb/tb_range_min_max_segment_tree.sv
